// ----- rtl/srsl_pkg.sv -----
// srsl_pkg: shared types, codes and helpers of the s-record stream loader
// used by srsl_front, srsl_queue, srsl_back and the top level
`timescale 1ns / 1ps
package srsl_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_LINE    = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TYPE     = 3'd1;
	localparam logic [2:0] ST_NO_HEX   = 3'd2;
	localparam logic [2:0] ST_SHORT    = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;
	localparam logic [2:0] ST_RANGE    = 3'd5;

	// register indexes
	localparam logic REG_WINDOW_START  = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_S       = 8'h53;

	// commands from front to back
	typedef enum logic [2:0] {
		CMD_DATA  = 3'b001,
		CMD_CLOSE = 3'b010,
		CMD_EOI   = 3'b100
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic        reportable;  // line was a record with characters
		logic [2:0]  pre_status;  // outcome of type, hex, length, checksum checks
		logic        need_range;  // data record that passed, window check pending
		logic [31:0] address;     // record address, or data offset for data
		logic [32:0] end_addr;    // record end without wrap
		logic [7:0]  data_byte;
	} cmd_t;

	// hex digit decode, bit 4 set on a non-hex character
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'd48 && c <= 8'd57) v = 5'(c - 8'd48);
		else if (c >= 8'd65 && c <= 8'd70) v = 5'(c - 8'd65 + 8'd10);
		else if (c >= 8'd97 && c <= 8'd102) v = 5'(c - 8'd97 + 8'd10);
		return v;
	endfunction

	// address size in bytes of a data record type
	function automatic logic [2:0] address_bytes(input logic [7:0] t);
		logic [2:0] a;
		a = 3'd0;
		if (t == 8'h31) a = 3'd2;
		else if (t == 8'h32) a = 3'd3;
		else if (t == 8'h33) a = 3'd4;
		return a;
	endfunction

endpackage

// ----- rtl/srecord_stream_loader_top.sv -----
// srecord_stream_loader_top: streaming s-record parser top level
// depends on srsl_pkg, srsl_front, srsl_queue, srsl_back
//
// usage:
//  - text enters one character per transfer on the input channel
//    (in_valid/in_ready, character, end_of_input); newline closes a line
//  - results leave on the output channel (out_valid/out_ready): tentative
//    data bytes with window offset, a line outcome per record line until a
//    record fails, and a summary for each end_of_input transfer
//  - window_start (index 0) and window_length (index 1) are written through
//    cfg_we/cfg_index/cfg_data while the block is idle
//  - throughput: one character per cycle while the command queue is not
//    full; a result passes from its queue entry, written at the transfer
//    edge, into the result register, which is loaded when the entry is popped
//  - a two-entry command queue separates decode from the result register;
//    when the receiver stalls, input is still taken until the queue fills
//  - reset clears line state, registers and sticky status
`timescale 1ns / 1ps
module srecord_stream_loader_top #(
	parameter int LINE_CHARS = 515
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] offset,
	output logic [7:0]  data_byte,
	output logic [2:0]  status,
	output logic [31:0] loaded_length,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import srsl_pkg::*;

	logic        in_fire;
	logic        push;
	logic        full;
	logic        pop;
	logic        not_empty;
	logic [31:0] window_start;
	cmd_t        push_cmd;
	cmd_t        head;

	assign in_ready = !full;
	assign in_fire  = in_valid && in_ready;

	srsl_front #(.LINE_CHARS(LINE_CHARS)) u_front (
		.clk, .arst_n, .in_fire, .character, .end_of_input, .window_start,
		.push, .cmd(push_cmd)
	);

	srsl_queue u_queue (
		.clk, .arst_n, .push, .push_cmd, .full, .pop, .not_empty, .head
	);

	srsl_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .window_start,
		.cmd_valid(not_empty), .cmd(head), .pop,
		.out_valid, .out_ready, .kind, .offset, .data_byte, .status, .loaded_length
	);

endmodule

// ----- rtl/srsl_front.sv -----
// srsl_front: per-character line tracking and hex pair decode
// depends on srsl_pkg; emits commands toward srsl_queue
`timescale 1ns / 1ps
module srsl_front #(
	parameter int LINE_CHARS = 515
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [7:0]          character,
	input  logic                end_of_input,
	input  logic [31:0]         window_start,
	output logic                push,
	output srsl_pkg::cmd_t      cmd
);
	import srsl_pkg::*;

	localparam int PW = $clog2(LINE_CHARS + 1);

	logic [PW-1:0] pos_q;
	logic          is_record_q;
	logic [7:0]    type_q;
	logic [3:0]    high_q;
	logic          pending_q;
	logic          stopped_q;
	logic [PW-1:0] pairs_q;
	logic [7:0]    len_q;
	logic [7:0]    sum_q;
	logic [7:0]    last_q;
	logic [31:0]   addr_q;

	logic [4:0]  hex;
	logic [2:0]  alen;
	logic [7:0]  pair_byte;
	logic [2:0]  pre_status;
	logic        need_range;
	logic        is_close;
	logic        pair_done;
	logic [31:0] data_off;
	logic [32:0] end_addr;

	assign hex       = hex_value(character);
	assign alen      = address_bytes(type_q);
	assign pair_byte = {high_q, hex[3:0]};
	assign is_close  = in_fire && (end_of_input || (character == CHAR_NEWLINE && pos_q != '0));

	// a hex pair completes on this character
	assign pair_done = in_fire && !end_of_input && character != CHAR_NEWLINE
		&& 32'(pos_q) < 32'(LINE_CHARS) && pos_q > PW'(1) && is_record_q
		&& !stopped_q && !hex[4] && pending_q;

	// record checks that need no window
	always_comb begin
		need_range = 1'b0;
		if (type_q < 8'h30 || type_q > 8'h39 || type_q == 8'h34) pre_status = ST_TYPE;
		else if (pairs_q == '0) pre_status = ST_NO_HEX;
		else if (32'(len_q) >= 32'(pairs_q)) pre_status = ST_SHORT;
		else if (8'hFF - sum_q != last_q) pre_status = ST_CHECKSUM;
		else if (alen == 3'd0) pre_status = ST_OK;
		else if (8'(alen) + 8'd1 >= len_q) pre_status = ST_RANGE;
		else begin
			pre_status = ST_OK;
			need_range = 1'b1;
		end
	end

	assign data_off = addr_q + 32'(pairs_q) - 32'(alen) - 32'd1 - window_start;
	assign end_addr = 33'(addr_q) + 33'(len_q) - 33'(alen) - 33'd1;

	// command build
	always_comb begin
		cmd = '0;
		cmd.op = CMD_DATA;
		push = 1'b0;
		if (is_close) begin
			cmd.op         = end_of_input ? CMD_EOI : CMD_CLOSE;
			cmd.reportable = is_record_q && pos_q != '0;
			cmd.pre_status = pre_status;
			cmd.need_range = need_range;
			cmd.address    = addr_q;
			cmd.end_addr   = end_addr;
			push           = end_of_input || is_record_q;
		end else if (pair_done && alen != 3'd0 && 32'(pairs_q) > 32'(alen)
			&& 32'(pairs_q) < 32'(len_q)) begin
			cmd.address   = data_off;
			cmd.data_byte = pair_byte;
			push          = 1'b1;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; is_record_q <= 1'b0; type_q <= '0; high_q <= '0;
			pending_q <= 1'b0; stopped_q <= 1'b0; pairs_q <= '0; len_q <= '0;
			sum_q <= '0; last_q <= '0; addr_q <= '0;
		end else if (is_close) begin
			pos_q <= '0; is_record_q <= 1'b0; type_q <= '0; high_q <= '0;
			pending_q <= 1'b0; stopped_q <= 1'b0; pairs_q <= '0; len_q <= '0;
			sum_q <= '0; last_q <= '0; addr_q <= '0;
		end else if (in_fire && !end_of_input && character != CHAR_NEWLINE
			&& 32'(pos_q) < 32'(LINE_CHARS)) begin
			pos_q <= pos_q + PW'(1);
			if (pos_q == '0) begin
				is_record_q <= (character == CHAR_S);
			end else if (is_record_q && pos_q == PW'(1)) begin
				type_q <= character;
			end else if (is_record_q && !stopped_q) begin
				if (hex[4]) begin
					stopped_q <= 1'b1;
				end else if (!pending_q) begin
					high_q    <= hex[3:0];
					pending_q <= 1'b1;
				end else begin
					pending_q <= 1'b0;
					if (pairs_q != '0) sum_q <= sum_q + last_q;
					last_q  <= pair_byte;
					pairs_q <= pairs_q + PW'(1);
					if (pairs_q == '0) len_q <= pair_byte;
					else if (alen != 3'd0 && 32'(pairs_q) <= 32'(alen))
						addr_q <= {addr_q[23:0], pair_byte};
				end
			end
		end
	end

endmodule

// ----- rtl/srsl_queue.sv -----
// srsl_queue: two-entry command queue between front and back
// depends on srsl_pkg for the command type
`timescale 1ns / 1ps
module srsl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srsl_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output srsl_pkg::cmd_t head
);
	import srsl_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; count_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && not_empty) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push && !full) - 2'(pop && not_empty);
		end
	end

endmodule

// ----- rtl/srsl_back.sv -----
// srsl_back: window check, sticky status, loaded length and result register
// depends on srsl_pkg; takes commands from srsl_queue
`timescale 1ns / 1ps
module srsl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data,
	output logic [31:0]    window_start,
	input  logic           cmd_valid,
	input  srsl_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     kind,
	output logic [31:0]    offset,
	output logic [7:0]     data_byte,
	output logic [2:0]     status,
	output logic [31:0]    loaded_length
);
	import srsl_pkg::*;

	logic [31:0] ws_q;
	logic [31:0] wl_q;
	logic [32:0] limit_q;
	logic [2:0]  sticky_q;
	logic [32:0] greatest_q;

	logic [2:0]  new_status;
	logic [2:0]  new_sticky;
	logic [32:0] new_greatest;
	logic        produce;

	logic [1:0]  kind_d;
	logic [31:0] offset_d;
	logic [7:0]  data_byte_d;
	logic [2:0]  status_d;
	logic [31:0] loaded_d;

	assign window_start = ws_q;
	assign pop = cmd_valid && (!out_valid || out_ready);

	// record outcome with window check
	always_comb begin
		new_status   = cmd.pre_status;
		new_greatest = greatest_q;
		if (cmd.need_range) begin
			if (cmd.address < ws_q || cmd.end_addr > limit_q) new_status = ST_RANGE;
			else if (cmd.end_addr > greatest_q) new_greatest = cmd.end_addr;
		end
		new_sticky = sticky_q;
		if (cmd.op != CMD_DATA && cmd.reportable && sticky_q == ST_OK) new_sticky = new_status;
		if (new_sticky != ST_OK) new_greatest = greatest_q;
	end

	always_comb begin
		case (cmd.op)
			CMD_DATA:  produce = (sticky_q == ST_OK);
			CMD_CLOSE: produce = cmd.reportable && sticky_q == ST_OK;
			CMD_EOI:   produce = 1'b1;
			default:   produce = 1'b0;
		endcase
	end

	// configuration and sticky state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= '0; wl_q <= '0; limit_q <= '0; sticky_q <= ST_OK; greatest_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_WINDOW_START) ws_q <= cfg_data;
			if (cfg_we && cfg_index == REG_WINDOW_LENGTH) wl_q <= cfg_data;
			limit_q <= 33'(ws_q) + 33'(wl_q);
			if (pop && cmd.op != CMD_DATA) begin
				sticky_q   <= new_sticky;
				greatest_q <= new_greatest;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= produce;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result fields by command
	always_comb begin
		kind_d      = KIND_DATA;
		offset_d    = '0;
		data_byte_d = '0;
		status_d    = ST_OK;
		loaded_d    = '0;
		case (cmd.op)
			CMD_DATA: begin
				offset_d    = cmd.address;
				data_byte_d = cmd.data_byte;
			end
			CMD_CLOSE: begin
				kind_d   = KIND_LINE;
				status_d = new_status;
			end
			CMD_EOI: begin
				kind_d   = KIND_SUMMARY;
				status_d = new_sticky;
				if (new_sticky == ST_OK && new_greatest > 33'(ws_q))
					loaded_d = 32'(new_greatest - 33'(ws_q));
			end
			default: kind_d = KIND_DATA;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind          <= kind_d;
			offset        <= offset_d;
			data_byte     <= data_byte_d;
			status        <= status_d;
			loaded_length <= loaded_d;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for srecord_stream_loader_top
// depends on srsl_pkg and srecord_stream_loader_top; builds s-record text,
// predicts every result with a local parser model and checks the output channel
`timescale 1ns / 1ps
module testbench;
	import srsl_pkg::*;

	localparam int LINE_LIMIT = 515;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_3 = 8'h33;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_5 = 8'h35;
	localparam logic [7:0] CH_7 = 8'h37;
	localparam logic [7:0] CH_8 = 8'h38;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// record damage kinds
	localparam int DMG_NONE = 0;
	localparam int DMG_CHECKSUM = 1;
	localparam int DMG_SHORT = 2;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} text_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] offset;
		logic [7:0]  data_byte;
		logic [2:0]  status;
		logic [31:0] loaded_length;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  character;
	logic        end_of_input;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [31:0] offset;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [31:0] loaded_length;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	srecord_stream_loader_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.character(character), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .offset(offset), .data_byte(data_byte),
		.status(status), .loaded_length(loaded_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	text_item_t char_queue[$];
	result_t    pending_results[$];
	int         fail_count = 0;
	int         cycle_count = 0;
	int         gen_count = 0;
	int         send_gap = 0;
	int         rx_hold_left = 0;
	bit         fast_mode = 0;
	bit         in_fire = 0;
	text_item_t cur_item;

	// parser model state
	int          p_pos;
	bit          p_is_rec;
	logic [7:0]  p_type;
	logic [3:0]  p_hi;
	bit          p_nib;
	bit          p_stop;
	int          p_pairs;
	logic [7:0]  p_len;
	logic [7:0]  p_sum;
	logic [7:0]  p_last;
	logic [31:0] p_addr;
	logic [2:0]  p_sticky;
	logic [32:0] p_great;
	logic [31:0] p_ws;
	logic [31:0] p_wl;

	// clock
	initial clk = 0;
	always #2 clk = ~clk;

	function automatic int digit_of(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		return -1;
	endfunction

	function automatic int addr_size(logic [7:0] t);
		case (t)
			CH_1: return 2;
			CH_2: return 3;
			CH_3: return 4;
			default: return 0;
		endcase
	endfunction

	function void clear_line();
		p_pos = 0;
		p_is_rec = 0;
		p_type = 0;
		p_hi = 0;
		p_nib = 0;
		p_stop = 0;
		p_pairs = 0;
		p_len = 0;
		p_sum = 0;
		p_last = 0;
		p_addr = 0;
	endfunction

	// outcome of a finished record line, updates the greatest end
	function automatic logic [2:0] judge_record();
		int a;
		logic [33:0] rec_end, lim;
		if (p_type < CH_0 || p_type > CH_9 || p_type == CH_4) return ST_TYPE;
		if (p_pairs < 1) return ST_NO_HEX;
		if (int'(p_len) + 1 > p_pairs) return ST_SHORT;
		if (8'(8'hFF - p_sum) != p_last) return ST_CHECKSUM;
		a = addr_size(p_type);
		if (a == 0) return ST_OK;
		if (1 + a >= int'(p_len)) return ST_RANGE;
		if (p_addr < p_ws) return ST_RANGE;
		rec_end = 34'(p_addr) + 34'(int'(p_len) - 1 - a);
		lim = 34'(p_ws) + 34'(p_wl);
		if (rec_end > lim) return ST_RANGE;
		if (rec_end > 34'(p_great)) p_great = 33'(rec_end);
		return ST_OK;
	endfunction

	function automatic int close_current();
		int r;
		r = -1;
		if (p_pos > 0 && p_is_rec && p_sticky == ST_OK) begin
			p_sticky = judge_record();
			r = int'(p_sticky);
		end
		clear_line();
		return r;
	endfunction

	function automatic void expect_result(logic [1:0] k, logic [31:0] off, logic [7:0] db,
			logic [2:0] st, logic [31:0] ll);
		result_t e;
		e.kind = k;
		e.offset = off;
		e.data_byte = db;
		e.status = st;
		e.loaded_length = ll;
		pending_results.push_back(e);
	endfunction

	// one accepted character through the parser model
	function automatic void srec_model_step(logic [7:0] c, logic eoi);
		int r, h, a, idx;
		logic [7:0] b;
		logic [31:0] ll;
		if (eoi) begin
			r = close_current();
			ll = '0;
			if (p_sticky == ST_OK && p_great > {1'b0, p_ws}) ll = 32'(p_great - {1'b0, p_ws});
			expect_result(KIND_SUMMARY, '0, '0, p_sticky, ll);
			return;
		end
		if (c == CHAR_NEWLINE) begin
			if (p_pos == 0) return;
			r = close_current();
			if (r >= 0) expect_result(KIND_LINE, '0, '0, 3'(r), '0);
			return;
		end
		if (p_pos >= LINE_LIMIT) return;
		p_pos++;
		if (p_pos == 1) begin
			p_is_rec = (c == CHAR_S);
			return;
		end
		if (!p_is_rec) return;
		if (p_pos == 2) begin
			p_type = c;
			return;
		end
		if (p_stop) return;
		h = digit_of(c);
		if (h < 0) begin
			p_stop = 1;
			return;
		end
		if (!p_nib) begin
			p_hi = 4'(h);
			p_nib = 1;
			return;
		end
		p_nib = 0;
		b = {p_hi, 4'(h)};
		idx = p_pairs;
		if (idx > 0) p_sum = p_sum + p_last;
		p_last = b;
		p_pairs = idx + 1;
		if (idx == 0) begin
			p_len = b;
			return;
		end
		a = addr_size(p_type);
		if (a == 0) return;
		if (idx <= a) begin
			p_addr = {p_addr[23:0], b};
			return;
		end
		if (idx < int'(p_len) && p_sticky == ST_OK)
			expect_result(KIND_DATA, p_addr + 32'(idx - 1 - a) - p_ws, b, ST_OK, '0);
	endfunction

	// text generation
	task automatic put_char(logic [7:0] c, logic eoi = 0);
		text_item_t t;
		t.ch = c;
		t.eoi = eoi;
		char_queue.push_back(t);
		gen_count++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_char(s[i]);
	endtask

	task automatic put_hex(logic [7:0] b);
		logic [3:0] v;
		for (int i = 1; i >= 0; i--) begin
			v = b[i*4 +: 4];
			if (v < 10) put_char(CH_0 + v);
			else put_char(8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10));
		end
	endtask

	task automatic put_record(logic [7:0] t, int ab, logic [31:0] addr, int n,
			int damage = DMG_NONE, bit newline = 1);
		logic [7:0] bytes[$];
		logic [7:0] sum;
		bytes.push_back(8'(ab + n + 1));
		for (int i = ab - 1; i >= 0; i--) bytes.push_back(addr[i*8 +: 8]);
		for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
		sum = 0;
		foreach (bytes[i]) sum = sum + bytes[i];
		bytes.push_back(8'hFF - sum);
		if (damage == DMG_CHECKSUM) bytes[bytes.size()-1] ^= 8'(1 << $urandom_range(0, 7));
		if (damage == DMG_SHORT) void'(bytes.pop_back());
		put_char(CHAR_S);
		put_char(t);
		foreach (bytes[i]) put_hex(bytes[i]);
		if (!newline) return;
		case ($urandom_range(0, 9))
			0, 1: put_char(CH_CR);
			2: begin
				put_char(CH_SPACE);
				put_char(8'($urandom));
			end
			default: ;
		endcase
		put_char(CHAR_NEWLINE);
	endtask

	// a data record placed inside the current window
	task automatic put_window_record(int n_req);
		longint unsigned lo, hi, top, span;
		logic [31:0] addr;
		int n, min_ab, ab;
		n = n_req;
		if (longint'(p_wl) < n) n = int'(p_wl);
		lo = p_ws;
		top = longint'(p_ws) + longint'(p_wl);
		if (top > 64'h1_0000_0000) top = 64'h1_0000_0000;
		hi = top - n;
		span = hi - lo;
		case ($urandom_range(0, 4))
			0: addr = 32'(lo);
			1: addr = 32'(hi);
			default: addr = 32'(lo + ({$urandom, $urandom} % (span + 1)));
		endcase
		min_ab = (addr <= 32'hFFFF) ? 2 : (addr <= 32'hFF_FFFF) ? 3 : 4;
		ab = $urandom_range(min_ab, 4);
		if (ab + n + 1 > 255) n = 254 - ab;
		put_record(CH_0 + 8'(ab - 1), ab, addr, n);
	endtask

	task automatic put_plain_record();
		case ($urandom_range(0, 4))
			0: put_record(CH_0, 2, 0, $urandom_range(0, 12));
			1: put_record(CH_5, 2, $urandom_range(0, 65535), 0);
			2: put_record(CH_7, 4, $urandom, 0);
			3: put_record(CH_8, 3, $urandom_range(0, 24'hFF_FFFF), 0);
			default: put_record(CH_9, 2, $urandom_range(0, 65535), 0);
		endcase
	endtask

	task automatic put_random_text(int count);
		int stop_at, r, n;
		logic [7:0] c;
		stop_at = gen_count + count;
		while (gen_count < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 68) begin
				n = $urandom_range(0, 99);
				if (n < 85) put_window_record($urandom_range(1, 8));
				else if (n < 98) put_window_record($urandom_range(9, 40));
				else put_window_record(251);
			end else if (r < 78) put_plain_record();
			else if (r < 90) begin
				// non-record line, any character but newline
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++) begin
					do c = 8'($urandom); while (c == CHAR_NEWLINE || (i == 0 && c == CHAR_S));
					put_char(c);
				end
				put_char(CHAR_NEWLINE);
			end else if (r < 94) put_char(CHAR_NEWLINE);
			else if (r < 97) put_char(8'($urandom), 1);
			else if (r < 98) begin
				// overlong line, tail is dropped
				put_char(8'h23);
				for (int i = 0; i < 560; i++) begin
					do c = 8'($urandom); while (c == CHAR_NEWLINE);
					put_char(c);
				end
				put_char(CHAR_NEWLINE);
			end else begin
				// record closed by end of input
				put_window_record(4);
				void'(char_queue.pop_back());
				put_char(8'($urandom), 1);
			end
		end
	endtask

	// one failing record, then the status sticks
	task automatic put_fault();
		case ($urandom_range(0, 6))
			0: put_record(CH_4, 2, 0, 2);
			1: put_text("S1zz\n");
			2: put_record(CH_3, 4, p_ws, 2, DMG_SHORT);
			3: put_record(CH_3, 4, p_ws, 2, DMG_CHECKSUM);
			4: put_record(CH_1, 2, 0, 0);
			5: put_record(CH_3, 4, p_ws - 1, 1);
			default: put_text("S\n");
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (fast_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_WINDOW_START) p_ws = value;
		else p_wl = value;
	endtask

	task automatic set_window(logic [31:0] ws, logic [31:0] wl);
		write_reg(REG_WINDOW_START, ws);
		write_reg(REG_WINDOW_LENGTH, wl);
	endtask

	// sender waits until all text is taken and every result is back
	task automatic drain();
		while (char_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 0;
			end else if (char_queue.size() != 0) begin
				cur_item = char_queue.pop_front();
				character <= cur_item.ch;
				end_of_input <= cur_item.eoi;
				in_valid <= 1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// input transfer feeds the model
	always @(posedge clk) begin
		in_fire = in_valid && in_ready;
		if (in_fire) srec_model_step(character, end_of_input);
	end

	// receiver stalls
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 0;
		end else if (fast_mode) begin
			out_ready <= 1;
		end else if ($urandom_range(0, 199) == 0) begin
			rx_hold_left = $urandom_range(10, 40);
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70);
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// output monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: kind %0d", kind);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				check_field("kind", 32'(e.kind), 32'(kind));
				check_field("offset", e.offset, offset);
				check_field("data_byte", 32'(e.data_byte), 32'(data_byte));
				check_field("status", 32'(e.status), 32'(status));
				check_field("loaded_length", e.loaded_length, loaded_length);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL srecord_stream_loader_top");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		character = 0;
		end_of_input = 0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		p_ws = 0;
		p_wl = 0;
		p_sticky = ST_OK;
		p_great = 0;
		clear_line();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: small window covering 16-bit addresses
		set_window(32'h0, 32'h1_0000);
		put_record(CH_0, 2, 0, 4);
		put_record(CH_1, 2, 16'h0000, 1);
		put_record(CH_1, 2, 16'hFFF0, 16);
		put_record(CH_2, 3, 24'h00_0100, 3);
		put_record(CH_3, 4, 32'h0000_0200, 2);
		put_text("# comment\n\n");
		put_record(CH_5, 2, 3, 0);
		put_record(CH_9, 2, 0, 0);
		put_char(8'h00, 1);
		put_record(CH_1, 2, 16'h0010, 2, DMG_NONE, 0);
		put_char(8'hFF, 1);
		put_char(CHAR_NEWLINE, 1);
		put_random_text(120);
		drain();

		// top of the address space, receiver held off to fill the block
		set_window(32'hFFFF_FFF0, 32'h10);
		@(posedge clk);
		rx_hold_left = 300;
		put_record(CH_3, 4, 32'hFFFF_FFFF, 1);
		put_random_text(150);
		drain();

		// whole address space, no idling
		set_window(32'h0, 32'hFFFF_FFFF);
		fast_mode = 1;
		put_record(CH_3, 4, 32'h1234_0000, 120);
		put_random_text(150);
		drain();
		fast_mode = 0;

		// random window
		set_window($urandom, $urandom_range(1, 32'h1_0000));
		put_random_text(150);
		put_char(8'h00, 1);
		drain();

		// failing record, then nothing but summaries
		set_window(32'h8000_0000, 32'h0);
		put_plain_record();
		put_char(8'h00, 1);
		put_fault();
		put_random_text(60);
		put_char(8'h00, 1);
		put_char(8'h00, 1);
		drain();

		if (fail_count == 0) $display("PASS srecord_stream_loader_top");
		else $display("FAIL srecord_stream_loader_top");
		$finish;
	end

endmodule

// ----- srecord_stream_loader_top.f -----
rtl/srsl_pkg.sv
rtl/srsl_front.sv
rtl/srsl_queue.sv
rtl/srsl_back.sv
rtl/srecord_stream_loader_top.sv
tb/sv/testbench.sv
